/* rtl/triangle_normal_stress_magnitude_top_defines.svh */
// ----------------------------------------------------------------------------
// triangle_normal_stress_magnitude_top_defines.svh
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_NORMAL_STRESS_MAGNITUDE_TOP_DEFINES_SVH
`define TRIANGLE_NORMAL_STRESS_MAGNITUDE_TOP_DEFINES_SVH

// same-cycle implication
`define TNSM_ASSERT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define TNSM_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/tnsm_pkg.sv */
// ----------------------------------------------------------------------------
// tnsm_pkg
// shared types and constants of the normal traction magnitude block
// ----------------------------------------------------------------------------
package tnsm_pkg;

    localparam int COORD_BITS_DEF  = 21;
    localparam int STRESS_BITS_DEF = 32;
    localparam int VERTEX_W        = 63;
    localparam int STRESS_W        = 32;
    localparam int MAG_W           = 32;
    localparam int QUOT_BITS       = 32;

    typedef struct packed {
        logic [VERTEX_W-1:0]        vertex_a;
        logic [VERTEX_W-1:0]        vertex_b;
        logic [VERTEX_W-1:0]        vertex_c;
        logic signed [STRESS_W-1:0] stress_xx;
        logic signed [STRESS_W-1:0] stress_xy;
        logic signed [STRESS_W-1:0] stress_xz;
        logic signed [STRESS_W-1:0] stress_yy;
        logic signed [STRESS_W-1:0] stress_yz;
        logic signed [STRESS_W-1:0] stress_zz;
        logic                       last_element;
    } tri_beat_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             degenerate;
        logic             last_out;
    } res_beat_t;

    // side flags that travel with the divider stages
    typedef struct packed {
        logic sat;
        logic deg;
        logic last;
    } div_flags_t;

endpackage

/* rtl/tnsm_in_if.sv */
// ----------------------------------------------------------------------------
// tnsm_in_if
// triangle input channel, valid/ready
// ----------------------------------------------------------------------------
interface tnsm_in_if;
    logic                 valid;
    logic                 ready;
    tnsm_pkg::tri_beat_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tnsm_out_if.sv */
// ----------------------------------------------------------------------------
// tnsm_out_if
// result output channel, valid/ready
// ----------------------------------------------------------------------------
interface tnsm_out_if;
    logic                 valid;
    logic                 ready;
    tnsm_pkg::res_beat_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tnsm_div.sv */
// ----------------------------------------------------------------------------
// tnsm_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tnsm_div #(
    parameter int DEN_BITS = 2 * (2 * (tnsm_pkg::COORD_BITS_DEF + 1)) + 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [DEN_BITS+tnsm_pkg::QUOT_BITS-1:0] in_rem,
    input  logic [DEN_BITS-1:0]            in_den,
    input  tnsm_pkg::div_flags_t           in_flags,
    output logic                           out_valid,
    output logic [tnsm_pkg::QUOT_BITS-1:0] out_quot,
    output tnsm_pkg::div_flags_t           out_flags
);

    localparam int QB = tnsm_pkg::QUOT_BITS;
    localparam int RW = DEN_BITS + QB;

    logic                  valid_reg [QB];
    logic [RW-1:0]         rem_reg   [QB];
    logic [DEN_BITS-1:0]   den_reg   [QB];
    logic [QB-1:0]         quot_reg  [QB];
    tnsm_pkg::div_flags_t  flags_reg [QB];

    for (genvar j = 0; j < QB; j++)
    begin : g_stage
        logic                 v_in;
        logic [RW-1:0]        rem_in;
        logic [DEN_BITS-1:0]  den_in;
        logic [QB-1:0]        quot_in;
        tnsm_pkg::div_flags_t flags_in;
        logic [RW-1:0]        trial;
        logic                 take;

        if (j == 0)
        begin : g_first
            assign v_in     = in_valid;
            assign rem_in   = in_rem;
            assign den_in   = in_den;
            assign quot_in  = '0;
            assign flags_in = in_flags;
        end
        else
        begin : g_next
            assign v_in     = valid_reg[j-1];
            assign rem_in   = rem_reg[j-1];
            assign den_in   = den_reg[j-1];
            assign quot_in  = quot_reg[j-1];
            assign flags_in = flags_reg[j-1];
        end

        // bit QB-1-j of the quotient
        assign trial = RW'(den_in) << (QB - 1 - j);
        assign take  = rem_in >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]   <= take ? rem_in - trial : rem_in;
                den_reg[j]   <= den_in;
                quot_reg[j]  <= quot_in | (QB'(take) << (QB - 1 - j));
                flags_reg[j] <= flags_in;
            end
        end
    end

    assign out_valid = valid_reg[QB-1];
    assign out_quot  = quot_reg[QB-1];
    assign out_flags = flags_reg[QB-1];

endmodule

/* rtl/triangle_normal_stress_magnitude_top.sv */
// ----------------------------------------------------------------------------
// triangle_normal_stress_magnitude_top
// absolute normal traction |n'Sn| of a stress tensor on a triangle's normal
// ----------------------------------------------------------------------------
// usage:
//  - triangle: one beat per triangle, three packed Q11.10 vertices, six
//    Q16.16 stress components and a batch-end mark
//  - result: one beat per triangle, in order, magnitude as unsigned Q16.16
//    (saturated), a degenerate flag for zero-area triangles and the mark
//  - an accepted triangle beat passes through 10 arithmetic stages, 32
//    divider stages (one quotient bit each) and the output register
//  - throughput is one triangle per cycle when not stalled; the 32-stage
//    divider and the split 44x44 and 88x32 products are fully pipelined
//  - when the receiver stalls a held result, the whole pipe freezes; the
//    first stage still takes a beat if it is empty
//  - reset clears every valid bit, the pipe comes up empty and ready
// ----------------------------------------------------------------------------
module triangle_normal_stress_magnitude_top #(
    parameter int COORD_BITS  = tnsm_pkg::COORD_BITS_DEF,
    parameter int STRESS_BITS = tnsm_pkg::STRESS_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tnsm_in_if.sink     triangle,
    tnsm_out_if.source  result
);

    localparam int EW  = COORD_BITS + 1;      // edge vector component
    localparam int PW  = 2 * EW;              // cross product partial
    localparam int CW  = PW + 1;              // signed normal component
    localparam int MW  = PW;                  // normal magnitude
    localparam int LO  = (MW + 1) / 2;
    localparam int PPW = 2 * MW;              // ci*cj
    localparam int DW  = PPW + 2;             // c.c
    localparam int K   = (PPW + 2) / 3;       // chunk for stress multiply
    localparam int SW  = STRESS_BITS;
    localparam int TW  = PPW + SW + 1;        // doubled term magnitude
    localparam int NW  = TW + 4;              // signed numerator
    localparam int QB  = tnsm_pkg::QUOT_BITS;
    localparam int RW  = DW + QB;

    // pair and stress index of the six quadratic-form terms
    localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PB [6] = '{0, 1, 2, 1, 2, 2};
    localparam int SI [6] = '{0, 3, 5, 1, 2, 4};

    logic en;
    logic en1;

    // ---------------- stage 1: unpack, edge vectors
    logic                   v1_reg;
    logic                   last1_reg;
    logic signed [EW-1:0]   e1_reg [3];
    logic signed [EW-1:0]   e2_reg [3];
    logic signed [SW-1:0]   s1_reg [6];
    logic signed [EW-1:0]   e1_next [3];
    logic signed [EW-1:0]   e2_next [3];
    logic signed [SW-1:0]   s1_next [6];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_next[i] = EW'(signed'(triangle.data.vertex_b[i*COORD_BITS +: COORD_BITS]))
                       - EW'(signed'(triangle.data.vertex_a[i*COORD_BITS +: COORD_BITS]));
            e2_next[i] = EW'(signed'(triangle.data.vertex_c[i*COORD_BITS +: COORD_BITS]))
                       - EW'(signed'(triangle.data.vertex_a[i*COORD_BITS +: COORD_BITS]));
        end
        s1_next[0] = signed'(triangle.data.stress_xx[SW-1:0]);
        s1_next[1] = signed'(triangle.data.stress_xy[SW-1:0]);
        s1_next[2] = signed'(triangle.data.stress_xz[SW-1:0]);
        s1_next[3] = signed'(triangle.data.stress_yy[SW-1:0]);
        s1_next[4] = signed'(triangle.data.stress_yz[SW-1:0]);
        s1_next[5] = signed'(triangle.data.stress_zz[SW-1:0]);
    end

    // ---------------- stage 2: cross product partials
    logic                   v2_reg;
    logic                   last2_reg;
    logic signed [PW-1:0]   xp_reg [6];
    logic signed [SW-1:0]   s2_reg [6];
    logic signed [PW-1:0]   xp_next [6];

    always_comb
    begin
        xp_next[0] = e1_reg[1] * e2_reg[2];
        xp_next[1] = e1_reg[2] * e2_reg[1];
        xp_next[2] = e1_reg[2] * e2_reg[0];
        xp_next[3] = e1_reg[0] * e2_reg[2];
        xp_next[4] = e1_reg[0] * e2_reg[1];
        xp_next[5] = e1_reg[1] * e2_reg[0];
    end

    // ---------------- stage 3: normal vector as sign and magnitude
    logic                   v3_reg;
    logic                   last3_reg;
    logic [MW-1:0]          cmag_reg [3];
    logic                   cneg_reg [3];
    logic signed [SW-1:0]   s3_reg [6];
    logic [MW-1:0]          cmag_next [3];
    logic                   cneg_next [3];

    always_comb
    begin
        logic signed [CW-1:0] cv;
        logic [CW-1:0]        ca;
        for (int i = 0; i < 3; i++)
        begin
            cv = CW'(xp_reg[2*i]) - CW'(xp_reg[2*i+1]);
            ca = cv[CW-1] ? -cv : cv;
            cmag_next[i] = ca[MW-1:0];
            cneg_next[i] = cv[CW-1];
        end
    end

    // ---------------- stage 4: ci*cj split into four partial products
    logic                   v4_reg;
    logic                   last4_reg;
    logic                   deg4_reg;
    logic [2*LO-1:0]        pp_reg [6][4];
    logic                   tneg4_reg [6];
    logic [SW-1:0]          smag4_reg [6];
    logic [2*LO-1:0]        pp_next [6][4];
    logic                   tneg4_next [6];
    logic [SW-1:0]          smag4_next [6];

    always_comb
    begin
        logic [LO-1:0] alo;
        logic [LO-1:0] ahi;
        logic [LO-1:0] blo;
        logic [LO-1:0] bhi;
        logic signed [SW-1:0] sv;
        for (int k = 0; k < 6; k++)
        begin
            alo = cmag_reg[PA[k]][LO-1:0];
            ahi = LO'(cmag_reg[PA[k]] >> LO);
            blo = cmag_reg[PB[k]][LO-1:0];
            bhi = LO'(cmag_reg[PB[k]] >> LO);
            pp_next[k][0] = alo * blo;
            pp_next[k][1] = alo * bhi;
            pp_next[k][2] = ahi * blo;
            pp_next[k][3] = ahi * bhi;
            sv = s3_reg[SI[k]];
            smag4_next[k] = sv[SW-1] ? SW'(-sv) : SW'(sv);
            tneg4_next[k] = cneg_reg[PA[k]] ^ cneg_reg[PB[k]] ^ sv[SW-1];
        end
    end

    // ---------------- stage 5: ci*cj assembled
    logic                   v5_reg;
    logic                   last5_reg;
    logic                   deg5_reg;
    logic [PPW-1:0]         pm_reg [6];
    logic                   tneg5_reg [6];
    logic [SW-1:0]          smag5_reg [6];
    logic [PPW-1:0]         pm_next [6];

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            pm_next[k] = PPW'(pp_reg[k][0])
                       + ((PPW'(pp_reg[k][1]) + PPW'(pp_reg[k][2])) << LO)
                       + (PPW'(pp_reg[k][3]) << (2 * LO));
        end
    end

    // ---------------- stage 6: c.c and stress times ci*cj partials
    logic                   v6_reg;
    logic                   last6_reg;
    logic                   deg6_reg;
    logic [DW-1:0]          den6_reg;
    logic [K+SW-1:0]        tp_reg [6][3];
    logic                   tneg6_reg [6];
    logic [DW-1:0]          den6_next;
    logic [K+SW-1:0]        tp_next [6][3];

    always_comb
    begin
        den6_next = DW'(pm_reg[0]) + DW'(pm_reg[1]) + DW'(pm_reg[2]);
        for (int k = 0; k < 6; k++)
        begin
            tp_next[k][0] = K'(pm_reg[k]) * smag5_reg[k];
            tp_next[k][1] = K'(pm_reg[k] >> K) * smag5_reg[k];
            tp_next[k][2] = K'(pm_reg[k] >> (2 * K)) * smag5_reg[k];
        end
    end

    // ---------------- stage 7: signed terms, off-diagonal ones doubled
    logic                   v7_reg;
    logic                   last7_reg;
    logic                   deg7_reg;
    logic [DW-1:0]          den7_reg;
    logic signed [NW-1:0]   term_reg [6];
    logic signed [NW-1:0]   term_next [6];

    always_comb
    begin
        logic [TW-2:0]  tm;
        logic [NW-1:0]  tz;
        for (int k = 0; k < 6; k++)
        begin
            tm = (TW-1)'(tp_reg[k][0])
               + ((TW-1)'(tp_reg[k][1]) << K)
               + ((TW-1)'(tp_reg[k][2]) << (2 * K));
            tz = (k >= 3) ? (NW'(tm) << 1) : NW'(tm);
            term_next[k] = tneg6_reg[k] ? -signed'(tz) : signed'(tz);
        end
    end

    // ---------------- stage 8: pairwise sums
    logic                   v8_reg;
    logic                   last8_reg;
    logic                   deg8_reg;
    logic [DW-1:0]          den8_reg;
    logic signed [NW-1:0]   sa_reg [3];

    // ---------------- stage 9: numerator
    logic                   v9_reg;
    logic                   last9_reg;
    logic                   deg9_reg;
    logic [DW-1:0]          den9_reg;
    logic signed [NW-1:0]   num_reg;

    // ---------------- stage 10: magnitude and saturation check
    logic                   v10_reg;
    logic [RW-1:0]          rem10_reg;
    logic [DW-1:0]          den10_reg;
    tnsm_pkg::div_flags_t   flags10_reg;
    logic [NW-1:0]          nabs;
    tnsm_pkg::div_flags_t   flags10_next;

    always_comb
    begin
        nabs = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
        flags10_next.sat  = nabs >= (NW'(den9_reg) << QB);
        flags10_next.deg  = deg9_reg;
        flags10_next.last = last9_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= triangle.valid;
            end
            if (en)
            begin
                v2_reg  <= v1_reg;
                v3_reg  <= v2_reg;
                v4_reg  <= v3_reg;
                v5_reg  <= v4_reg;
                v6_reg  <= v5_reg;
                v7_reg  <= v6_reg;
                v8_reg  <= v7_reg;
                v9_reg  <= v8_reg;
                v10_reg <= v9_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            last1_reg <= triangle.data.last_element;
            e1_reg    <= e1_next;
            e2_reg    <= e2_next;
            s1_reg    <= s1_next;
        end
        if (en)
        begin
            last2_reg <= last1_reg;
            xp_reg    <= xp_next;
            s2_reg    <= s1_reg;

            last3_reg <= last2_reg;
            cmag_reg  <= cmag_next;
            cneg_reg  <= cneg_next;
            s3_reg    <= s2_reg;

            last4_reg <= last3_reg;
            deg4_reg  <= (cmag_reg[0] == '0) && (cmag_reg[1] == '0) && (cmag_reg[2] == '0);
            pp_reg    <= pp_next;
            tneg4_reg <= tneg4_next;
            smag4_reg <= smag4_next;

            last5_reg <= last4_reg;
            deg5_reg  <= deg4_reg;
            pm_reg    <= pm_next;
            tneg5_reg <= tneg4_reg;
            smag5_reg <= smag4_reg;

            last6_reg <= last5_reg;
            deg6_reg  <= deg5_reg;
            den6_reg  <= den6_next;
            tp_reg    <= tp_next;
            tneg6_reg <= tneg5_reg;

            last7_reg <= last6_reg;
            deg7_reg  <= deg6_reg;
            den7_reg  <= den6_reg;
            term_reg  <= term_next;

            last8_reg <= last7_reg;
            deg8_reg  <= deg7_reg;
            den8_reg  <= den7_reg;
            sa_reg[0] <= term_reg[0] + term_reg[1];
            sa_reg[1] <= term_reg[2] + term_reg[3];
            sa_reg[2] <= term_reg[4] + term_reg[5];

            last9_reg <= last8_reg;
            deg9_reg  <= deg8_reg;
            den9_reg  <= den8_reg;
            num_reg   <= sa_reg[0] + sa_reg[1] + sa_reg[2];

            // below the saturation bound the remainder fits RW bits
            rem10_reg   <= nabs[RW-1:0];
            den10_reg   <= den9_reg;
            flags10_reg <= flags10_next;
        end
    end

    // ---------------- stages 11..42: quotient bits
    logic                   div_valid;
    logic [QB-1:0]          div_quot;
    tnsm_pkg::div_flags_t   div_flags;

    tnsm_div #(
        .DEN_BITS (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v10_reg),
        .in_rem    (rem10_reg),
        .in_den    (den10_reg),
        .in_flags  (flags10_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_flags (div_flags)
    );

    // ---------------- output register
    logic                 out_valid_reg;
    tnsm_pkg::res_beat_t  out_data_reg;
    tnsm_pkg::res_beat_t  out_data_next;

    always_comb
    begin
        out_data_next.degenerate = div_flags.deg;
        out_data_next.last_out   = div_flags.last;
        if (div_flags.deg)
        begin
            out_data_next.magnitude = '0;
        end
        else if (div_flags.sat)
        begin
            out_data_next.magnitude = '1;
        end
        else
        begin
            out_data_next.magnitude = tnsm_pkg::MAG_W'(div_quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // the pipe moves whenever the output slot is free or being drained;
    // an empty first stage can load on its own
    assign en             = !out_valid_reg || result.ready;
    assign en1            = en || !v1_reg;
    assign triangle.ready = en1;
    assign result.valid   = out_valid_reg;
    assign result.data    = out_data_reg;

endmodule

/* rtl/tnsm_checker.sv */
// ----------------------------------------------------------------------------
// tnsm_checker
// port-level checks of the normal traction magnitude block
// ----------------------------------------------------------------------------
`include "triangle_normal_stress_magnitude_top_defines.svh"

module tnsm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [tnsm_pkg::MAG_W-1:0]  magnitude,
    input logic                        degenerate
);

    `TNSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `TNSM_ASSERT_NEXT(a_mag_hold, out_valid && !out_ready, $stable(magnitude), "stalled magnitude changed")
    `TNSM_ASSERT(a_deg_zero, out_valid && degenerate, magnitude == '0, "degenerate result nonzero")
    `TNSM_ASSERT(a_ready_free, !out_valid, in_ready, "input blocked with empty output")

endmodule

bind triangle_normal_stress_magnitude_top tnsm_checker u_tnsm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (triangle.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .magnitude  (result.data.magnitude),
    .degenerate (result.data.degenerate)
);
